// ----- sv/pitt_pkg.sv -----
// Shared types, constants and width helpers for the point-in-triangle test unit.
// No dependencies.
package pitt_pkg;

    localparam int COORD_BITS_DEF     = 16;
    localparam int BARY_FRAC_BITS_DEF = 16;

    localparam int PLANE_TOL_W   = 32;
    localparam int BARY_TOL_W    = 16;
    localparam int BARY_TOL_FRAC = 16;
    localparam int CFG_DATA_W    = 32;
    localparam int CFG_ADDR_W    = 3;
    localparam int QUEUE_DEPTH   = 4;

    localparam logic [PLANE_TOL_W-1:0] PLANE_TOL_RST = PLANE_TOL_W'(1);
    localparam logic [BARY_TOL_W-1:0]  BARY_TOL_RST  = BARY_TOL_W'(1);

    typedef enum logic [0:0] {
        REG_PLANE_TOL = 1'b0,
        REG_BARY_TOL  = 1'b1
    } reg_idx_t;

    typedef enum logic [1:0] {
        VERDICT_INSIDE     = 2'd0,
        VERDICT_OFF_PLANE  = 2'd1,
        VERDICT_OUTSIDE    = 2'd2,
        VERDICT_DEGENERATE = 2'd3
    } verdict_t;

    typedef struct packed {
        logic [PLANE_TOL_W-1:0] plane_tol;
        logic [BARY_TOL_W-1:0]  bary_tol;
    } cfg_t;

    // vector arithmetic wraps at 64 bits
    function automatic int clip64(int w);
        return (w > 64) ? 64 : w;
    endfunction

    function automatic int dot_w(int cb);
        return clip64(2 * (cb + 1) + 2);
    endfunction

endpackage

// ----- sv/pitt_if.sv -----
// Valid/ready channel interfaces for query items and result items.
// Depends on pitt_pkg.
interface pitt_item_if #(
    parameter int COORD_BITS = pitt_pkg::COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic signed [COORD_BITS-1:0] point_z;
    logic signed [COORD_BITS-1:0] vert_a_x;
    logic signed [COORD_BITS-1:0] vert_a_y;
    logic signed [COORD_BITS-1:0] vert_a_z;
    logic signed [COORD_BITS-1:0] vert_b_x;
    logic signed [COORD_BITS-1:0] vert_b_y;
    logic signed [COORD_BITS-1:0] vert_b_z;
    logic signed [COORD_BITS-1:0] vert_c_x;
    logic signed [COORD_BITS-1:0] vert_c_y;
    logic signed [COORD_BITS-1:0] vert_c_z;

    modport source (
        output valid, point_x, point_y, point_z, vert_a_x, vert_a_y, vert_a_z,
               vert_b_x, vert_b_y, vert_b_z, vert_c_x, vert_c_y, vert_c_z,
        input  ready
    );
    modport sink (
        input  valid, point_x, point_y, point_z, vert_a_x, vert_a_y, vert_a_z,
               vert_b_x, vert_b_y, vert_b_z, vert_c_x, vert_c_y, vert_c_z,
        output ready
    );
endinterface

interface pitt_res_if;
    logic       valid;
    logic       ready;
    logic       inside_res;
    logic [1:0] verdict;

    modport source (output valid, inside_res, verdict, input ready);
    modport sink (input valid, inside_res, verdict, output ready);
endinterface

// ----- sv/pitt_cfg.sv -----
// APB-style register file: plane_tol and bary_tol.
// Depends on pitt_pkg.
module pitt_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [pitt_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [pitt_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [pitt_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready,
    output pitt_pkg::cfg_t                      cfg
);

    logic [pitt_pkg::PLANE_TOL_W-1:0] plane_tol_reg;
    logic [pitt_pkg::BARY_TOL_W-1:0]  bary_tol_reg;
    pitt_pkg::reg_idx_t               idx;
    logic                             wr;

    assign idx    = pitt_pkg::reg_idx_t'(paddr[2]);
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_tol_reg <= pitt_pkg::PLANE_TOL_RST;
            bary_tol_reg  <= pitt_pkg::BARY_TOL_RST;
        end
        else if (wr)
        begin
            unique case (idx)
                pitt_pkg::REG_PLANE_TOL: plane_tol_reg <= pwdata[pitt_pkg::PLANE_TOL_W-1:0];
                pitt_pkg::REG_BARY_TOL:  bary_tol_reg  <= pwdata[pitt_pkg::BARY_TOL_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            pitt_pkg::REG_PLANE_TOL: prdata = pitt_pkg::CFG_DATA_W'(plane_tol_reg);
            pitt_pkg::REG_BARY_TOL:  prdata = pitt_pkg::CFG_DATA_W'(bary_tol_reg);
        endcase
    end

    assign cfg.plane_tol = plane_tol_reg;
    assign cfg.bary_tol  = bary_tol_reg;

endmodule

// ----- sv/pitt_front.sv -----
// Front pipeline: edge vectors, normal, plane test and the five dot products.
// Depends on pitt_pkg and pitt_item_if.
module pitt_front #(
    parameter  int COORD_BITS = pitt_pkg::COORD_BITS_DEF,
    localparam int DotW       = pitt_pkg::dot_w(COORD_BITS)
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    pitt_item_if.sink                            item_in,
    input  logic [pitt_pkg::PLANE_TOL_W-1:0]     plane_tol,
    input  logic                                 q_full,
    output logic                                 q_push,
    output logic [5*DotW:0]                      q_data
);

    localparam int DiffW = COORD_BITS + 1;
    localparam int NpW   = pitt_pkg::clip64(2 * DiffW);
    localparam int NW    = pitt_pkg::clip64(2 * DiffW + 1);
    localparam int DpW   = pitt_pkg::clip64(2 * DiffW);
    localparam int NxpW  = pitt_pkg::clip64(NW + DiffW);
    localparam int NxW   = pitt_pkg::clip64(NxpW + 2);
    localparam int CmpW  = (NxW > pitt_pkg::PLANE_TOL_W) ? NxW : pitt_pkg::PLANE_TOL_W;
    localparam int NStg  = 7;

    logic signed [DiffW-1:0] x0_next [3];
    logic signed [DiffW-1:0] y0_next [3];
    logic signed [DiffW-1:0] z0_next [3];
    logic signed [DiffW-1:0] x0_reg  [3];
    logic signed [DiffW-1:0] y0_reg  [3];
    logic signed [DiffW-1:0] z0_reg  [3];
    logic signed [DiffW-1:0] x1_reg  [3];
    logic signed [DiffW-1:0] x2_reg  [3];
    logic signed [NpW-1:0]   np_next [6];
    logic signed [NpW-1:0]   np_reg  [6];
    logic signed [DpW-1:0]   dp_next [5][3];
    logic signed [DpW-1:0]   dp_reg  [5][3];
    logic signed [NW-1:0]    n_next  [3];
    logic signed [NW-1:0]    n_reg   [3];
    logic signed [DotW-1:0]  dot_next [5];
    logic signed [DotW-1:0]  dot2_reg [5];
    logic signed [DotW-1:0]  dot3_reg [5];
    logic signed [DotW-1:0]  dot4_reg [5];
    logic signed [DotW-1:0]  dot5_reg [5];
    logic signed [DotW-1:0]  dot6_reg [5];
    logic signed [NxpW-1:0]  nxp_next [3];
    logic signed [NxpW-1:0]  nxp_reg  [3];
    logic signed [NxW-1:0]   dpsum_next;
    logic signed [NxW-1:0]   dpsum_reg;
    logic [NxW-1:0]          mag_next;
    logic [NxW-1:0]          mag_reg;
    logic                    off_next;
    logic                    off_reg;
    logic [NStg-1:0]         vld_reg;
    logic                    adv;

    assign adv           = !(vld_reg[NStg-1] && q_full);
    assign item_in.ready = adv;
    assign q_push        = vld_reg[NStg-1] && !q_full;

    always_comb
    begin
        x0_next[0] = DiffW'(item_in.point_x)  - DiffW'(item_in.vert_a_x);
        x0_next[1] = DiffW'(item_in.point_y)  - DiffW'(item_in.vert_a_y);
        x0_next[2] = DiffW'(item_in.point_z)  - DiffW'(item_in.vert_a_z);
        y0_next[0] = DiffW'(item_in.vert_b_x) - DiffW'(item_in.vert_a_x);
        y0_next[1] = DiffW'(item_in.vert_b_y) - DiffW'(item_in.vert_a_y);
        y0_next[2] = DiffW'(item_in.vert_b_z) - DiffW'(item_in.vert_a_z);
        z0_next[0] = DiffW'(item_in.vert_c_x) - DiffW'(item_in.vert_a_x);
        z0_next[1] = DiffW'(item_in.vert_c_y) - DiffW'(item_in.vert_a_y);
        z0_next[2] = DiffW'(item_in.vert_c_z) - DiffW'(item_in.vert_a_z);

        np_next[0] = NpW'(y0_reg[1]) * NpW'(z0_reg[2]);
        np_next[1] = NpW'(y0_reg[2]) * NpW'(z0_reg[1]);
        np_next[2] = NpW'(y0_reg[2]) * NpW'(z0_reg[0]);
        np_next[3] = NpW'(y0_reg[0]) * NpW'(z0_reg[2]);
        np_next[4] = NpW'(y0_reg[0]) * NpW'(z0_reg[1]);
        np_next[5] = NpW'(y0_reg[1]) * NpW'(z0_reg[0]);

        // dot order: XY, YY, ZY, XZ, ZZ
        for (int i = 0; i < 3; i++)
        begin
            dp_next[0][i] = DpW'(x0_reg[i]) * DpW'(y0_reg[i]);
            dp_next[1][i] = DpW'(y0_reg[i]) * DpW'(y0_reg[i]);
            dp_next[2][i] = DpW'(z0_reg[i]) * DpW'(y0_reg[i]);
            dp_next[3][i] = DpW'(x0_reg[i]) * DpW'(z0_reg[i]);
            dp_next[4][i] = DpW'(z0_reg[i]) * DpW'(z0_reg[i]);
        end

        n_next[0] = NW'(np_reg[0]) - NW'(np_reg[1]);
        n_next[1] = NW'(np_reg[2]) - NW'(np_reg[3]);
        n_next[2] = NW'(np_reg[4]) - NW'(np_reg[5]);
        for (int k = 0; k < 5; k++)
        begin
            dot_next[k] = DotW'(dp_reg[k][0]) + DotW'(dp_reg[k][1]) + DotW'(dp_reg[k][2]);
        end

        for (int i = 0; i < 3; i++)
        begin
            nxp_next[i] = NxpW'(n_reg[i]) * NxpW'(x2_reg[i]);
        end

        dpsum_next = NxW'(nxp_reg[0]) + NxW'(nxp_reg[1]) + NxW'(nxp_reg[2]);
        mag_next   = dpsum_reg[NxW-1] ? (~dpsum_reg + 1'b1) : dpsum_reg;
        off_next   = CmpW'(mag_reg) > CmpW'(plane_tol);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[NStg-2:0], item_in.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x0_reg    <= x0_next;
            y0_reg    <= y0_next;
            z0_reg    <= z0_next;
            np_reg    <= np_next;
            dp_reg    <= dp_next;
            x1_reg    <= x0_reg;
            n_reg     <= n_next;
            dot2_reg  <= dot_next;
            x2_reg    <= x1_reg;
            nxp_reg   <= nxp_next;
            dot3_reg  <= dot2_reg;
            dpsum_reg <= dpsum_next;
            dot4_reg  <= dot3_reg;
            mag_reg   <= mag_next;
            dot5_reg  <= dot4_reg;
            off_reg   <= off_next;
            dot6_reg  <= dot5_reg;
        end
    end

    assign q_data = {off_reg, dot6_reg[4], dot6_reg[3], dot6_reg[2], dot6_reg[1], dot6_reg[0]};

endmodule

// ----- sv/pitt_fifo.sv -----
// Small register queue between the front and back pipelines.
// Depends on pitt_pkg.
module pitt_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = pitt_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [CntW-1:0]  count_reg;

    assign full     = count_reg == CntW'(DEPTH);
    assign empty    = count_reg == '0;
    assign pop_data = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
        else $error("queue pop while empty");
    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count lost a transaction");

endmodule

// ----- sv/pitt_back.sv -----
// Back pipeline: barycentric numerators, pipelined restoring division, range tests.
// Depends on pitt_pkg and pitt_res_if.
module pitt_back #(
    parameter  int COORD_BITS     = pitt_pkg::COORD_BITS_DEF,
    parameter  int BARY_FRAC_BITS = pitt_pkg::BARY_FRAC_BITS_DEF,
    localparam int DotW           = pitt_pkg::dot_w(COORD_BITS)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                q_empty,
    input  logic [5*DotW:0]                     q_data,
    output logic                                q_pop,
    input  logic [pitt_pkg::BARY_TOL_W-1:0]     bary_tol,
    pitt_res_if.source                          res_out
);

    localparam int Frac   = BARY_FRAC_BITS;
    localparam int MulW   = 2 * DotW;
    localparam int RemW   = (MulW + 1 > 128) ? 128 : MulW + 1;
    localparam int NumW   = (RemW + Frac > 128) ? 128 : RemW + Frac;
    localparam int Q      = Frac + 2;
    localparam int CW     = Q + 3;
    localparam int TolShl = (Frac > pitt_pkg::BARY_TOL_FRAC) ? Frac - pitt_pkg::BARY_TOL_FRAC : 0;
    localparam int TolShr = (Frac < pitt_pkg::BARY_TOL_FRAC) ? pitt_pkg::BARY_TOL_FRAC - Frac : 0;
    localparam int TolW   = pitt_pkg::BARY_TOL_W + TolShl;
    localparam int NStg   = Q + 5;

    logic signed [DotW-1:0] d_xy, d_yy, d_zy, d_xz, d_zz;
    logic                   q_off;

    // B0
    logic signed [MulW-1:0] pda_reg, pdb_reg, pua_reg, pub_reg, pva_reg, pvb_reg;
    pitt_pkg::verdict_t     code0_reg;
    // B1
    logic signed [RemW-1:0] den1_reg, nu1_reg, nv1_reg;
    pitt_pkg::verdict_t     code1_reg;
    // B2
    logic signed [NumW-1:0] num_u, num_v;
    logic [NumW-1:0]        mag_u_next, mag_v_next, mag_u_reg, mag_v_reg;
    logic                   neg_u2_reg, neg_v2_reg;
    logic [RemW-1:0]        den2_reg;
    pitt_pkg::verdict_t     code2_next, code2_reg;
    // divider, index 0 is the initial step
    logic [NumW-1:0]        hi_u, hi_v;
    logic [RemW-1:0]        rem_u_next [Q+1];
    logic [RemW-1:0]        rem_v_next [Q+1];
    logic [Q-1:0]           qm_u_next  [Q+1];
    logic [Q-1:0]           qm_v_next  [Q+1];
    logic [RemW-1:0]        rem_u_reg  [Q+1];
    logic [RemW-1:0]        rem_v_reg  [Q+1];
    logic [Q-1:0]           qm_u_reg   [Q+1];
    logic [Q-1:0]           qm_v_reg   [Q+1];
    logic [RemW-1:0]        den_d_reg  [Q+1];
    logic                   neg_u_reg  [Q+1];
    logic                   neg_v_reg  [Q+1];
    logic                   ovf_next;
    logic                   ovf_reg    [Q+1];
    pitt_pkg::verdict_t     code_d_reg [Q+1];
    logic [RemW-1:0]        t_u, t_v;
    logic                   ge_u, ge_v;
    // BU
    logic signed [CW-1:0]   u_next, v_next, u_reg, v_reg;
    logic                   ovf_bu_reg;
    pitt_pkg::verdict_t     code_bu_reg;
    // output
    logic [TolW-1:0]        tol_al;
    logic signed [CW-1:0]   tol_s, one_s, lo_s, hi_s, w_s;
    logic                   outside;
    pitt_pkg::verdict_t     verdict_next, verdict_reg;
    logic                   out_vld_reg;
    logic [NStg-1:0]        vld_reg;
    logic                   adv;

    assign adv   = !out_vld_reg || res_out.ready;
    assign q_pop = adv && !q_empty;

    assign d_xy  = q_data[0*DotW +: DotW];
    assign d_yy  = q_data[1*DotW +: DotW];
    assign d_zy  = q_data[2*DotW +: DotW];
    assign d_xz  = q_data[3*DotW +: DotW];
    assign d_zz  = q_data[4*DotW +: DotW];
    assign q_off = q_data[5*DotW];

    always_comb
    begin
        num_u      = NumW'(nu1_reg) << Frac;
        num_v      = NumW'(nv1_reg) << Frac;
        mag_u_next = num_u[NumW-1] ? (~num_u + 1'b1) : num_u;
        mag_v_next = num_v[NumW-1] ? (~num_v + 1'b1) : num_v;
        code2_next = code1_reg;
        if (code1_reg == pitt_pkg::VERDICT_INSIDE && (den1_reg[RemW-1] || den1_reg == '0))
        begin
            code2_next = pitt_pkg::VERDICT_DEGENERATE;
        end

        hi_u          = mag_u_reg >> Q;
        hi_v          = mag_v_reg >> Q;
        ovf_next      = (hi_u >= NumW'(den2_reg)) || (hi_v >= NumW'(den2_reg));
        rem_u_next[0] = RemW'(hi_u);
        rem_v_next[0] = RemW'(hi_v);
        qm_u_next[0]  = mag_u_reg[Q-1:0];
        qm_v_next[0]  = mag_v_reg[Q-1:0];

        t_u  = '0;
        t_v  = '0;
        ge_u = 1'b0;
        ge_v = 1'b0;
        for (int i = 1; i <= Q; i++)
        begin
            t_u           = {rem_u_reg[i-1][RemW-2:0], qm_u_reg[i-1][Q-1]};
            t_v           = {rem_v_reg[i-1][RemW-2:0], qm_v_reg[i-1][Q-1]};
            ge_u          = t_u >= den_d_reg[i-1];
            ge_v          = t_v >= den_d_reg[i-1];
            rem_u_next[i] = ge_u ? t_u - den_d_reg[i-1] : t_u;
            rem_v_next[i] = ge_v ? t_v - den_d_reg[i-1] : t_v;
            qm_u_next[i]  = {qm_u_reg[i-1][Q-2:0], ge_u};
            qm_v_next[i]  = {qm_v_reg[i-1][Q-2:0], ge_v};
        end

        u_next = neg_u_reg[Q] ? CW'(0) - CW'(qm_u_reg[Q]) : CW'(qm_u_reg[Q]);
        v_next = neg_v_reg[Q] ? CW'(0) - CW'(qm_v_reg[Q]) : CW'(qm_v_reg[Q]);

        tol_al  = (TolW'(bary_tol) << TolShl) >> TolShr;
        tol_s   = CW'(tol_al);
        one_s   = CW'(1) << Frac;
        lo_s    = CW'(0) - tol_s;
        hi_s    = one_s + tol_s;
        w_s     = one_s - u_reg - v_reg;
        outside = ovf_bu_reg
               || (u_reg < lo_s) || (hi_s < u_reg)
               || (v_reg < lo_s) || (hi_s < v_reg)
               || (w_s < lo_s)   || (hi_s < w_s);
        verdict_next = code_bu_reg;
        if (code_bu_reg == pitt_pkg::VERDICT_INSIDE && outside)
        begin
            verdict_next = pitt_pkg::VERDICT_OUTSIDE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg     <= {vld_reg[NStg-2:0], !q_empty};
            out_vld_reg <= vld_reg[NStg-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pda_reg   <= MulW'(d_yy) * MulW'(d_zz);
            pdb_reg   <= MulW'(d_zy) * MulW'(d_zy);
            pua_reg   <= MulW'(d_xy) * MulW'(d_zz);
            pub_reg   <= MulW'(d_xz) * MulW'(d_zy);
            pva_reg   <= MulW'(d_xz) * MulW'(d_yy);
            pvb_reg   <= MulW'(d_xy) * MulW'(d_zy);
            code0_reg <= q_off ? pitt_pkg::VERDICT_OFF_PLANE : pitt_pkg::VERDICT_INSIDE;

            den1_reg  <= RemW'(pda_reg) - RemW'(pdb_reg);
            nu1_reg   <= RemW'(pua_reg) - RemW'(pub_reg);
            nv1_reg   <= RemW'(pva_reg) - RemW'(pvb_reg);
            code1_reg <= code0_reg;

            mag_u_reg  <= mag_u_next;
            mag_v_reg  <= mag_v_next;
            neg_u2_reg <= num_u[NumW-1];
            neg_v2_reg <= num_v[NumW-1];
            den2_reg   <= den1_reg;
            code2_reg  <= code2_next;

            rem_u_reg     <= rem_u_next;
            rem_v_reg     <= rem_v_next;
            qm_u_reg      <= qm_u_next;
            qm_v_reg      <= qm_v_next;
            den_d_reg[0]  <= den2_reg;
            neg_u_reg[0]  <= neg_u2_reg;
            neg_v_reg[0]  <= neg_v2_reg;
            ovf_reg[0]    <= ovf_next;
            code_d_reg[0] <= code2_reg;
            for (int i = 1; i <= Q; i++)
            begin
                den_d_reg[i]  <= den_d_reg[i-1];
                neg_u_reg[i]  <= neg_u_reg[i-1];
                neg_v_reg[i]  <= neg_v_reg[i-1];
                ovf_reg[i]    <= ovf_reg[i-1];
                code_d_reg[i] <= code_d_reg[i-1];
            end

            u_reg       <= u_next;
            v_reg       <= v_next;
            ovf_bu_reg  <= ovf_reg[Q];
            code_bu_reg <= code_d_reg[Q];

            verdict_reg <= verdict_next;
        end
    end

    assign res_out.valid      = out_vld_reg;
    assign res_out.verdict    = verdict_reg;
    assign res_out.inside_res = verdict_reg == pitt_pkg::VERDICT_INSIDE;

endmodule

// ----- sv/point_in_triangle_test_unit.sv -----
// Throughput: one transaction per cycle while res_out.ready stays high, else the pipes stall;
// the restoring divider has one stage per quotient bit.
// A 4-entry queue decouples the plane-test front from the division back end.
// Reset: asynchronous, clears all valid state; plane_tol and bary_tol reset to 1.
// Top level; depends on pitt_pkg, pitt_if, pitt_cfg, pitt_front, pitt_fifo, pitt_back.
module point_in_triangle_test_unit #(
    parameter int COORD_BITS     = pitt_pkg::COORD_BITS_DEF,
    parameter int BARY_FRAC_BITS = pitt_pkg::BARY_FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    pitt_item_if.sink                           item_in,
    pitt_res_if.source                          res_out,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [pitt_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [pitt_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [pitt_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready
);

    localparam int DotW = pitt_pkg::dot_w(COORD_BITS);
    localparam int QW   = 5 * DotW + 1;

    pitt_pkg::cfg_t cfg;
    logic           q_push;
    logic           q_pop;
    logic           q_full;
    logic           q_empty;
    logic [QW-1:0]  q_in;
    logic [QW-1:0]  q_out;

    pitt_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pitt_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .item_in   (item_in),
        .plane_tol (cfg.plane_tol),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_in)
    );

    pitt_fifo #(
        .WIDTH (QW),
        .DEPTH (pitt_pkg::QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty)
    );

    pitt_back #(
        .COORD_BITS     (COORD_BITS),
        .BARY_FRAC_BITS (BARY_FRAC_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_data   (q_out),
        .q_pop    (q_pop),
        .bary_tol (cfg.bary_tol),
        .res_out  (res_out)
    );

endmodule
